@@ hdl/lfg_pkg.sv @@
// ----------------------------------------------------------------------------
// lfg_pkg
// Shared constants, types and the log2 fraction table for the log-frequency
// gain interpolator.
// ----------------------------------------------------------------------------
package lfg_pkg;

	localparam int MAX_POINTS = 64;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int FREQ_W     = 32;
	localparam int GAIN_W     = 16;
	localparam int LOG_W      = 21;   // Q5.16
	localparam int NUM_W      = 40;   // rounded numerator magnitude
	localparam int CYC_W      = $clog2(NUM_W + 1);

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// one stored calibration point
	typedef struct packed {
		logic [FREQ_W-1:0]        freq;
		logic signed [GAIN_W-1:0] gain;
	} point_t;

	typedef logic [15:0] frac_tab_t [64];

	// log2(1 + k/64) in Q0.16 by repeated squaring, evaluated at elaboration
	function automatic frac_tab_t build_frac_tab();
		frac_tab_t   t;
		logic [63:0] x;
		logic [15:0] r;
		for (int k = 0; k < 64; k++) begin
			x = (64'd1 << 30) + (64'(k) << 24);
			r = '0;
			for (int b = 0; b < 16; b++) begin
				x = (x * x) >> 30;
				r = {r[14:0], 1'b0};
				if (x >= (64'd2 << 30)) begin
					r[0] = 1'b1;
					x    = x >> 1;
				end
			end
			t[k] = r;
		end
		return t;
	endfunction

	localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

@@ hdl/log_freq_gain_interpolator.sv @@
// Throughput: one transaction at a time; the segment walk reads one point per
// memory cycle and the rounded divide runs in a bit-serial unit.
// Reset: arst_n clears the point count and handshake state; the point memory
// is not cleared and its data is used only below the point count.
// ----------------------------------------------------------------------------
// log_freq_gain_interpolator
// Calibration table of (frequency, gain) points with log-frequency linear
// interpolation of the gain at a query frequency.
// ----------------------------------------------------------------------------
module log_freq_gain_interpolator
	import lfg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               mode,
	input  logic [FREQ_W-1:0]        frequency,
	input  logic signed [GAIN_W-1:0] gain_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [GAIN_W-1:0] result_gain,
	output logic [CNT_W-1:0]         point_count,
	output logic                     accepted,
	output logic                     table_ready
);

	typedef enum logic [3:0] {
		S_IDLE, S_FIRST, S_LAST, S_ENDS, S_WALK, S_LQ, S_L0, S_L1,
		S_MUL, S_DIVST, S_DIVW, S_FIN
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [ADDR_W-1:0]        rd_addr_q;
	logic [ADDR_W-1:0]        idx_q;
	logic [FREQ_W-1:0]        freq_q;
	logic [FREQ_W-1:0]        fa_q;
	logic [FREQ_W-1:0]        fb_q;
	logic signed [GAIN_W-1:0] ga_q;
	logic signed [GAIN_W-1:0] gb_q;
	logic signed [GAIN_W-1:0] glast_q;
	logic [LOG_W-1:0]         lq_q;
	logic [LOG_W-1:0]         l0_q;
	logic [LOG_W-1:0]         l1_q;
	logic signed [38:0]       prod_q;
	logic signed [GAIN_W-1:0] res_gain_q;
	logic                     res_acc_q;

	logic                     in_acc;
	logic                     do_write;
	point_t                   wr_point;
	point_t                   rd_point;
	logic [FREQ_W-1:0]        log_in;
	logic [LOG_W-1:0]         log_out;
	logic signed [LOG_W:0]    den_s;
	logic signed [LOG_W:0]    dl_s;
	logic signed [GAIN_W:0]   dg_s;
	logic                     prod_neg;
	logic [38:0]              mag;
	logic [NUM_W-1:0]         div_num;
	logic                     div_start;
	logic                     div_done;
	logic [NUM_W-1:0]         div_quot;
	logic signed [NUM_W+1:0]  q_s;
	logic signed [NUM_W+1:0]  sum_s;
	logic signed [GAIN_W-1:0] sat_gain;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign do_write = in_acc && (mode == MODE_APPEND) && (frequency != '0)
		&& (cnt_q < CNT_W'(MAX_POINTS));
	assign wr_point = '{freq: frequency, gain: gain_in};

	lfg_point_mem u_mem (
		.clk   (clk),
		.we    (do_write),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (wr_point),
		.raddr (rd_addr_q),
		.rdata (rd_point)
	);

	// shared log2 unit, one operand per state
	always_comb begin
		case (state_q)
			S_L0:    log_in = fa_q;
			S_L1:    log_in = fb_q;
			default: log_in = freq_q;
		endcase
	end

	lfg_log2 u_log (
		.value   (log_in),
		.log_val (log_out)
	);

	// interpolation arithmetic; the product is held through the divide
	assign den_s     = $signed({1'b0, l1_q}) - $signed({1'b0, l0_q});
	assign dl_s      = $signed({1'b0, lq_q}) - $signed({1'b0, l0_q});
	assign dg_s      = 17'(gb_q) - 17'(ga_q);
	assign prod_neg  = prod_q[38];
	assign mag       = prod_neg ? 39'(-prod_q) : 39'(prod_q);
	assign div_num   = NUM_W'(mag) + NUM_W'(den_s[LOG_W-1:1]);
	assign div_start = (state_q == S_DIVST);
	assign q_s       = prod_neg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
	assign sum_s     = (NUM_W+2)'(ga_q) + q_s;

	always_comb begin
		if (sum_s > (NUM_W+2)'(32767)) begin
			sat_gain = 16'sh7FFF;
		end else if (sum_s < -(NUM_W+2)'(32768)) begin
			sat_gain = 16'sh8000;
		end else begin
			sat_gain = GAIN_W'(sum_s);
		end
	end

	lfg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_s[LOG_W-1:0]),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid   <= 1'b0;
			rd_addr_q   <= '0;
			idx_q       <= '0;
			res_gain_q  <= '0;
			res_acc_q   <= 1'b0;
			result_gain <= '0;
			point_count <= '0;
			accepted    <= 1'b0;
			table_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_FIN) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						freq_q     <= frequency;
						res_gain_q <= '0;
						res_acc_q  <= do_write;
						rd_addr_q  <= '0;
						if (mode == MODE_CLEAR) begin
							cnt_q   <= '0;
							state_q <= S_FIN;
						end else if (do_write) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_FIN;
						end else if (mode == MODE_QUERY && cnt_q >= CNT_W'(2)) begin
							state_q <= S_FIRST;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIRST: begin
					rd_addr_q <= ADDR_W'(cnt_q - 1'b1);
					state_q   <= S_LAST;
				end
				S_LAST: begin
					fa_q      <= rd_point.freq;
					ga_q      <= rd_point.gain;
					rd_addr_q <= ADDR_W'(1);
					state_q   <= S_ENDS;
				end
				S_ENDS: begin
					glast_q   <= rd_point.gain;
					rd_addr_q <= ADDR_W'(2);
					idx_q     <= '0;
					if (freq_q <= fa_q) begin
						res_gain_q <= ga_q;
						state_q    <= S_FIN;
					end else if (freq_q >= rd_point.freq) begin
						res_gain_q <= rd_point.gain;
						state_q    <= S_FIN;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (freq_q >= fa_q && freq_q <= rd_point.freq) begin
						fb_q    <= rd_point.freq;
						gb_q    <= rd_point.gain;
						state_q <= S_LQ;
					end else if (CNT_W'(idx_q) + CNT_W'(2) == cnt_q) begin
						res_gain_q <= glast_q;
						state_q    <= S_FIN;
					end else begin
						fa_q      <= rd_point.freq;
						ga_q      <= rd_point.gain;
						idx_q     <= idx_q + 1'b1;
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				S_LQ: begin
					lq_q    <= log_out;
					state_q <= S_L0;
				end
				S_L0: begin
					l0_q    <= log_out;
					state_q <= S_L1;
				end
				S_L1: begin
					l1_q    <= log_out;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= 39'(dl_s) * 39'(dg_s);
					if (den_s <= 0) begin
						res_gain_q <= ga_q;
						state_q    <= S_FIN;
					end else begin
						state_q <= S_DIVST;
					end
				end
				S_DIVST: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						res_gain_q <= sat_gain;
						state_q    <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid || out_ready) begin
						out_valid   <= 1'b1;
						result_gain <= res_gain_q;
						point_count <= cnt_q;
						accepted    <= res_acc_q;
						table_ready <= (cnt_q >= CNT_W'(2));
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/lfg_point_mem.sv @@
// ----------------------------------------------------------------------------
// lfg_point_mem
// Calibration point store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lfg_point_mem
	import lfg_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  point_t            wdata,
	input  logic [ADDR_W-1:0] raddr,
	output point_t            rdata
);

	point_t mem_q [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/lfg_log2.sv @@
// ----------------------------------------------------------------------------
// lfg_log2
// Approximate log2 in Q5.16: leading-one position plus table fraction.
// ----------------------------------------------------------------------------
module lfg_log2
	import lfg_pkg::*;
(
	input  logic [FREQ_W-1:0] value,
	output logic [LOG_W-1:0]  log_val
);

	logic [4:0]        pos;
	logic [FREQ_W-1:0] norm;
	logic [5:0]        k;

	// leading-one search
	always_comb begin
		pos = '0;
		for (int i = 0; i < FREQ_W; i++) begin
			if (value[i]) begin
				pos = 5'(i);
			end
		end
	end

	// six bits below the leading one, zero-filled for small values
	always_comb begin
		if (pos >= 5'd6) begin
			norm = value >> (pos - 5'd6);
		end else begin
			norm = value << (5'd6 - pos);
		end
		k = norm[5:0];
		if (value == '0) begin
			log_val = '0;
		end else begin
			log_val = {pos, FRAC_TAB[k]};
		end
	end

endmodule

@@ hdl/lfg_divider.sv @@
// ----------------------------------------------------------------------------
// lfg_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfg_divider
	import lfg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [LOG_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	logic [LOG_W-1:0] rem_q;
	logic [LOG_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CYC_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LOG_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CYC_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CYC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? LOG_W'(trial - {1'b0, den_q}) : LOG_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

@@ hdl/lfg_checker.sv @@
// ----------------------------------------------------------------------------
// lfg_checker
// Port-level checks of the interpolator's result channel.
// ----------------------------------------------------------------------------
module lfg_checker
	import lfg_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [GAIN_W-1:0] result_gain,
	input logic [CNT_W-1:0]         point_count,
	input logic                     accepted,
	input logic                     table_ready
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_gain)
		&& $stable(point_count))
		else $error("result changed while stalled");

	// ready flag follows the count
	a_ready_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> table_ready == (point_count >= CNT_W'(2)))
		else $error("table_ready mismatch");

	// a stored append leaves at least one point
	a_acc_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> point_count != '0)
		else $error("accepted with empty table");

	// no gain without a usable table
	a_gain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !table_ready |-> result_gain == '0)
		else $error("gain from short table");

endmodule

bind log_freq_gain_interpolator lfg_checker u_lfg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_gain (result_gain),
	.point_count (point_count),
	.accepted    (accepted),
	.table_ready (table_ready)
);
